>>> src/npt_pkg.sv
// Shared types, codes and saturating helpers for the NURBS point and tangent evaluator.
package npt_pkg;

  localparam int BASIS_FRAC  = 32;
  localparam int DEGREE_CAP  = 3;
  localparam int CONTROL_CAP = 64;

  typedef logic signed [63:0] wide_t;

  localparam wide_t MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_KNOT = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_EVAL = 2'd2
  } kind_t;

  typedef enum logic {
    REG_DEGREE = 1'b0,
    REG_COUNT  = 1'b1
  } reg_index_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  // Operation request and response for the shared multiply and divide units
  typedef struct packed {
    logic       start;
    wide_t      a;
    wide_t      b;
    logic [5:0] shift;
  } op_req_t;

  typedef struct packed {
    logic  done;
    logic  sat;
    wide_t value;
  } op_rsp_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        w;
  } ctrl_entry_t;

  typedef struct packed {
    logic [1:0] degree;
    logic [6:0] count;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic  sat;
    wide_t v;
  } sat_sum_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } clamp_t;

  // Magnitude of a signed value as an unsigned word
  function automatic logic [63:0] mag(input wide_t a);
    logic [63:0] r;
    r = a[63] ? (~a + 64'd1) : a;
    return r;
  endfunction

  // Attach a sign to a magnitude that is at most MAXV
  function automatic wide_t apply_sign(input logic [63:0] m, input logic neg);
    logic [63:0] r;
    r = neg ? (~m + 64'd1) : m;
    return $signed(r);
  endfunction

  // Add with symmetric saturation to +-MAXV
  function automatic sat_sum_t sat_add(input wide_t a, input wide_t b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    sat_sum_t           r;
    s   = $signed({a[63], a}) + $signed({b[63], b});
    lim = $signed({1'b0, MAXV});
    if (s > lim) begin
      r.sat = 1'b1;
      r.v   = MAXV;
    end else if (s < -lim) begin
      r.sat = 1'b1;
      r.v   = -MAXV;
    end else begin
      r.sat = 1'b0;
      r.v   = $signed(s[63:0]);
    end
    return r;
  endfunction

  // Clamp a wide value to 32 bits
  function automatic clamp_t clamp32(input wide_t v);
    clamp_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.v   = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.v   = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.v   = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

>>> src/npt_if.sv
// Request and result channel interfaces of the NURBS evaluator.
interface npt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [6:0]         slot_index;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic [30:0]        weight_value;

  modport source (output valid, kind, slot_index, first_value, second_value, weight_value,
                  input ready);
  modport sink (input valid, kind, slot_index, first_value, second_value, weight_value,
                output ready);
endinterface

interface npt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] tangent_x;
  logic signed [31:0] tangent_y;
  logic [1:0]         status;

  modport source (output valid, point_x, point_y, tangent_x, tangent_y, status, input ready);
  modport sink (input valid, point_x, point_y, tangent_x, tangent_y, status, output ready);
endinterface

>>> src/npt_mul.sv
// Shared 64x64 magnitude multiplier built from four 32x32 partial products, with shift and
// saturation.
module npt_mul import npt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  op_req_t req,
  output op_rsp_t rsp
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [5:0]   sh;
  logic [2:0]   phase;
  logic         busy;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [127:0] shifted;
  logic         over;
  logic [63:0]  part;
  logic [6:0]   ofs;

  // Select the partial product for this phase
  always_comb begin
    case (phase[1:0])
      2'd0: part = ma[31:0] * mb[31:0];
      2'd1: part = ma[31:0] * mb[63:32];
      2'd2: part = ma[63:32] * mb[31:0];
      default: part = ma[63:32] * mb[63:32];
    endcase
  end

  // Weight of the product registered in the previous phase
  always_comb begin
    case (phase)
      3'd1: ofs = 7'd0;
      3'd2: ofs = 7'd32;
      3'd3: ofs = 7'd32;
      default: ofs = 7'd64;
    endcase
  end

  assign shifted = acc >> sh;
  assign over    = |shifted[127:63];

  // Advance the partial product sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      phase    <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        ma    <= mag(req.a);
        mb    <= mag(req.b);
        neg   <= req.a[63] ^ req.b[63];
        sh    <= req.shift;
        acc   <= '0;
        phase <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (phase < 3'd4) begin
          pp <= part;
        end
        if (phase >= 3'd1 && phase <= 3'd4) begin
          acc <= acc + ({64'd0, pp} << ofs);
        end
        if (phase == 3'd5) begin
          rsp.sat   <= over;
          rsp.value <= apply_sign(over ? MAXV : shifted[63:0], neg);
          rsp.done  <= 1'b1;
          busy      <= 1'b0;
        end
        phase <= phase + 3'd1;
      end
    end
  end

endmodule

>>> src/npt_div.sv
// Shared restoring divider: one quotient bit per cycle on a 64-bit magnitude, dividend
// pre-shifted left, quotient saturated.
module npt_div import npt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  op_req_t req,
  output op_rsp_t rsp
);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_SETUP,
    DV_ITER,
    DV_FIN
  } dv_state_t;

  dv_state_t    state;
  logic [63:0]  dm;
  logic [63:0]  nm;
  logic         neg;
  logic [5:0]   sh;
  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [63:0]  q;
  logic [5:0]   cnt;
  logic [127:0] n_full;
  logic [64:0]  r2;

  assign n_full = {64'd0, nm} << sh;
  assign r2     = {rem, lo[63]};

  // Sequence setup, bit steps and final sign
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DV_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (req.start) begin
            dm    <= mag(req.b);
            nm    <= mag(req.a);
            neg   <= req.a[63] ^ req.b[63];
            sh    <= req.shift;
            state <= DV_SETUP;
          end
        end
        DV_SETUP: begin
          if (dm == 64'd0) begin
            rsp.sat   <= 1'b0;
            rsp.value <= '0;
            rsp.done  <= 1'b1;
            state     <= DV_IDLE;
          end else if (n_full[127:64] >= dm) begin
            rsp.sat   <= 1'b1;
            rsp.value <= apply_sign(MAXV, neg);
            rsp.done  <= 1'b1;
            state     <= DV_IDLE;
          end else begin
            rem   <= n_full[127:64];
            lo    <= n_full[63:0];
            q     <= '0;
            cnt   <= 6'd63;
            state <= DV_ITER;
          end
        end
        DV_ITER: begin
          lo <= {lo[62:0], 1'b0};
          if (r2 >= {1'b0, dm}) begin
            rem <= 64'(r2 - {1'b0, dm});
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= r2[63:0];
            q   <= {q[62:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          rsp.sat   <= q[63];
          rsp.value <= apply_sign(q[63] ? MAXV : q, neg);
          rsp.done  <= 1'b1;
          state     <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

>>> src/npt_eval.sv
// Evaluation sequencer: span search, basis recursion, weighted sums and rational division,
// reading the knot and control memories and driving the shared arithmetic units.
module npt_eval import npt_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  localparam int KNOT_DEPTH  = CONTROL_CAP + DEGREE_CAP + 1,
  localparam int KW          = $clog2(KNOT_DEPTH),
  localparam int CW          = $clog2(CONTROL_CAP),
  localparam int DW          = $clog2(DEGREE_CAP + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] u,
  input  cfg_t               cfg,
  output logic [KW-1:0]      knot_addr,
  input  logic signed [31:0] knot_q,
  output logic [CW-1:0]      ctrl_addr,
  input  ctrl_entry_t        ctrl_q,
  output logic               idle,
  output logic               done,
  input  logic               take,
  output result_t            res
);

  localparam int SUM_AX  = 0;
  localparam int SUM_AY  = 1;
  localparam int SUM_W   = 2;
  localparam int SUM_DAX = 3;
  localparam int SUM_DAY = 4;
  localparam int SUM_DW  = 5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SP0, ST_SP1, ST_SP2, ST_BS0, ST_BS1,
    ST_TSTART, ST_KA, ST_KB, ST_DEN, ST_DIVW, ST_MULW, ST_NEXT, ST_DNW,
    ST_URD, ST_UCAP, ST_UWX, ST_UWY, ST_UPROD, ST_UPW,
    ST_FCHK, ST_FPX, ST_FPY, ST_FTX1, ST_FTX, ST_FTY1, ST_FTY, ST_FOUT, ST_DONE
  } state_t;

  state_t             state;
  logic signed [31:0] u_r;
  logic [DW-1:0]      p_r;
  logic [KW-1:0]      n_r;
  logic [KW-1:0]      span;
  logic [KW-1:0]      lo;
  logic [KW-1:0]      hi;
  logic [DW-1:0]      d;
  logic [DW-1:0]      j;
  logic [2:0]         k;
  logic               deriv;
  logic               left;
  logic               sat_flag;
  logic signed [31:0] ka_r;
  logic signed [31:0] cy_r;
  wide_t              wi_r;
  wide_t              wx;
  wide_t              wy;
  wide_t              acc_s;
  wide_t              px;
  wide_t              py;
  wide_t              tx;
  wide_t              prev [DEGREE_CAP+1];
  wide_t              cur  [DEGREE_CAP+1];
  wide_t              dn   [DEGREE_CAP+1];
  wide_t              sums [6];
  op_req_t            mul_req;
  op_rsp_t            mul_rsp;
  op_req_t            div_req;
  op_rsp_t            div_rsp;

  logic [DW-1:0]      p_calc;
  logic [KW-1:0]      n_calc;
  logic [KW:0]        mid_sum;
  logic [KW-1:0]      mid;
  logic [KW-1:0]      ka_idx;
  logic [KW-1:0]      kb_idx;
  logic [DW-1:0]      prev_idx;
  wide_t              prev_sel;
  wide_t              num;
  wide_t              den;
  wide_t              bsel;
  wide_t              osel;
  sat_sum_t           add_term;
  sat_sum_t           add_sum;
  sat_sum_t           add_tan;
  clamp_t             c_px;
  clamp_t             c_py;
  clamp_t             c_tx;
  clamp_t             c_ty;

  npt_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  npt_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Clamp the degree and control count
  always_comb begin
    int dg;
    int pm;
    int mm;
    dg = int'(cfg.degree);
    if (dg < 1) pm = 1;
    else if (dg > DEGREE_CAP) pm = DEGREE_CAP;
    else pm = dg;
    mm = int'(cfg.count);
    if (mm < pm + 1) mm = pm + 1;
    if (mm > CONTROL_CAP) mm = CONTROL_CAP;
    p_calc = DW'(pm);
    n_calc = KW'(mm - 1);
  end

  // Knot and control addresses
  always_comb begin
    int si;
    int di;
    int ji;
    int pi;
    si       = int'(span);
    di       = int'(d);
    ji       = int'(j);
    pi       = int'(p_r);
    mid_sum  = {1'b0, lo} + {1'b0, hi};
    mid      = mid_sum[KW:1];
    ka_idx   = left ? KW'(si - di + ji) : KW'(si - di + ji + 1);
    kb_idx   = left ? KW'(si + ji) : KW'(si + ji + 1);
    ctrl_addr = CW'(si - pi + ji);
    case (state)
      ST_SP0:  knot_addr = KW'(n_r + KW'(1));
      ST_SP1:  knot_addr = KW'(p_r);
      ST_BS0:  knot_addr = mid;
      ST_KA:   knot_addr = ka_idx;
      ST_KB:   knot_addr = kb_idx;
      default: knot_addr = '0;
    endcase
  end

  // Operand selection
  always_comb begin
    prev_idx = left ? DW'(j - DW'(1)) : j;
    prev_sel = prev[prev_idx];
    num      = left ? (wide_t'(u_r) - wide_t'(ka_r)) : (wide_t'(knot_q) - wide_t'(u_r));
    den      = wide_t'(knot_q) - wide_t'(ka_r);
    bsel     = (k < 3'd3) ? cur[j] : dn[j];
    case (k) inside
      3'd0, 3'd3: osel = wx;
      3'd1, 3'd4: osel = wy;
      default:    osel = wi_r;
    endcase
    add_term = sat_add(acc_s, (deriv && !left) ? -div_rsp.value
                                               : (deriv ? div_rsp.value : mul_rsp.value));
    add_sum  = sat_add(sums[k], mul_rsp.value);
    add_tan  = sat_add(sums[(state == ST_FTX1) ? SUM_DAX : SUM_DAY], -mul_rsp.value);
    c_px     = clamp32(px);
    c_py     = clamp32(py);
    c_tx     = clamp32(tx);
    c_ty     = clamp32(div_rsp.value);
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);

  // Sequence one evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            u_r      <= u;
            p_r      <= p_calc;
            n_r      <= n_calc;
            sat_flag <= 1'b0;
            for (int i = 0; i < 6; i++) sums[i] <= '0;
            state    <= ST_SP0;
          end
        end
        // Span search: clamp at both ends, then bisect
        ST_SP0: state <= ST_SP1;
        ST_SP1: begin
          if (u_r >= knot_q) begin
            span  <= n_r;
            state <= ST_TSTART;
          end else begin
            state <= ST_SP2;
          end
          prev[0] <= wide_t'(64'd1 << BASIS_FRAC);
          d       <= DW'(1);
          j       <= '0;
          deriv   <= 1'b0;
        end
        ST_SP2: begin
          if (u_r <= knot_q) begin
            span  <= KW'(p_r);
            state <= ST_TSTART;
          end else begin
            lo    <= KW'(p_r);
            hi    <= KW'(n_r + KW'(1));
            state <= ST_BS0;
          end
        end
        ST_BS0: begin
          if (hi - lo > KW'(1)) begin
            state <= ST_BS1;
          end else begin
            span  <= lo;
            state <= ST_TSTART;
          end
        end
        ST_BS1: begin
          if (u_r < knot_q) hi <= mid;
          else lo <= mid;
          state <= ST_BS0;
        end
        // One basis or derivative element, left term then right term
        ST_TSTART: begin
          acc_s <= '0;
          left  <= (j != '0);
          state <= ST_KA;
        end
        ST_KA: state <= ST_KB;
        ST_KB: begin
          ka_r  <= knot_q;
          state <= ST_DEN;
        end
        ST_DEN: begin
          if (den == '0) begin
            state <= ST_NEXT;
          end else begin
            div_req <= '{start: 1'b1, a: (deriv ? prev_sel : num), b: den,
                         shift: (deriv ? 6'(FRAC_BITS) : 6'(BASIS_FRAC))};
            state   <= ST_DIVW;
          end
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            if (deriv) begin
              acc_s    <= add_term.v;
              sat_flag <= sat_flag | div_rsp.sat | add_term.sat;
              state    <= ST_NEXT;
            end else begin
              sat_flag <= sat_flag | div_rsp.sat;
              mul_req  <= '{start: 1'b1, a: div_rsp.value, b: prev_sel,
                            shift: 6'(BASIS_FRAC)};
              state    <= ST_MULW;
            end
          end
        end
        ST_MULW: begin
          if (mul_rsp.done) begin
            acc_s    <= add_term.v;
            sat_flag <= sat_flag | mul_rsp.sat | add_term.sat;
            state    <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (left && j < d) begin
            left  <= 1'b0;
            state <= ST_KA;
          end else if (!deriv) begin
            cur[j] <= acc_s;
            if (j == d) begin
              j <= '0;
              if (d == p_r) begin
                deriv <= 1'b1;
              end else begin
                for (int i = 0; i <= DEGREE_CAP; i++) begin
                  prev[i] <= (DW'(i) == j) ? acc_s : cur[i];
                end
                d <= d + DW'(1);
              end
            end else begin
              j <= j + DW'(1);
            end
            state <= ST_TSTART;
          end else begin
            mul_req <= '{start: 1'b1, a: acc_s, b: wide_t'(64'(p_r)), shift: 6'd0};
            state   <= ST_DNW;
          end
        end
        ST_DNW: begin
          if (mul_rsp.done) begin
            dn[j]    <= mul_rsp.value;
            sat_flag <= sat_flag | mul_rsp.sat;
            if (j == p_r) begin
              j     <= '0;
              state <= ST_URD;
            end else begin
              j     <= j + DW'(1);
              state <= ST_TSTART;
            end
          end
        end
        // Weighted sums over the active control points
        ST_URD: state <= ST_UCAP;
        ST_UCAP: begin
          wi_r    <= wide_t'(64'(ctrl_q.w));
          cy_r    <= ctrl_q.y;
          mul_req <= '{start: 1'b1, a: wide_t'(64'(ctrl_q.w)), b: wide_t'(ctrl_q.x),
                       shift: 6'd0};
          state   <= ST_UWX;
        end
        ST_UWX: begin
          if (mul_rsp.done) begin
            wx      <= mul_rsp.value;
            mul_req <= '{start: 1'b1, a: wi_r, b: wide_t'(cy_r), shift: 6'd0};
            state   <= ST_UWY;
          end
        end
        ST_UWY: begin
          if (mul_rsp.done) begin
            wy    <= mul_rsp.value;
            k     <= '0;
            state <= ST_UPROD;
          end
        end
        ST_UPROD: begin
          mul_req <= '{start: 1'b1, a: bsel, b: osel, shift: 6'(BASIS_FRAC)};
          state   <= ST_UPW;
        end
        ST_UPW: begin
          if (mul_rsp.done) begin
            sums[k]  <= add_sum.v;
            sat_flag <= sat_flag | mul_rsp.sat | add_sum.sat;
            if (k == 3'd5) begin
              if (j == p_r) begin
                state <= ST_FCHK;
              end else begin
                j     <= j + DW'(1);
                state <= ST_URD;
              end
            end else begin
              k     <= k + 3'd1;
              state <= ST_UPROD;
            end
          end
        end
        // Rational point and tangent
        ST_FCHK: begin
          if (sums[SUM_W] == '0) begin
            res   <= '{point_x: '0, point_y: '0, tangent_x: '0, tangent_y: '0,
                       status: STATUS_ZERO_DEN};
            state <= ST_DONE;
          end else begin
            div_req <= '{start: 1'b1, a: sums[SUM_AX], b: sums[SUM_W], shift: 6'd0};
            state   <= ST_FPX;
          end
        end
        ST_FPX: begin
          if (div_rsp.done) begin
            px       <= div_rsp.value;
            sat_flag <= sat_flag | div_rsp.sat;
            div_req  <= '{start: 1'b1, a: sums[SUM_AY], b: sums[SUM_W], shift: 6'd0};
            state    <= ST_FPY;
          end
        end
        ST_FPY: begin
          if (div_rsp.done) begin
            py       <= div_rsp.value;
            sat_flag <= sat_flag | div_rsp.sat;
            mul_req  <= '{start: 1'b1, a: px, b: sums[SUM_DW], shift: 6'd0};
            state    <= ST_FTX1;
          end
        end
        ST_FTX1: begin
          if (mul_rsp.done) begin
            sat_flag <= sat_flag | mul_rsp.sat | add_tan.sat;
            div_req  <= '{start: 1'b1, a: add_tan.v, b: sums[SUM_W], shift: 6'd0};
            state    <= ST_FTX;
          end
        end
        ST_FTX: begin
          if (div_rsp.done) begin
            tx       <= div_rsp.value;
            sat_flag <= sat_flag | div_rsp.sat;
            mul_req  <= '{start: 1'b1, a: py, b: sums[SUM_DW], shift: 6'd0};
            state    <= ST_FTY1;
          end
        end
        ST_FTY1: begin
          if (mul_rsp.done) begin
            sat_flag <= sat_flag | mul_rsp.sat | add_tan.sat;
            div_req  <= '{start: 1'b1, a: add_tan.v, b: sums[SUM_W], shift: 6'd0};
            state    <= ST_FTY;
          end
        end
        ST_FTY: begin
          if (div_rsp.done) begin
            sat_flag <= sat_flag | div_rsp.sat;
            state    <= ST_FOUT;
          end
        end
        ST_FOUT: begin
          res.point_x   <= c_px.v;
          res.point_y   <= c_py.v;
          res.tangent_x <= c_tx.v;
          res.tangent_y <= c_ty.v;
          res.status    <= (sat_flag | c_px.sat | c_py.sat | c_tx.sat | c_ty.sat)
                           ? STATUS_SAT : STATUS_OK;
          state         <= ST_DONE;
        end
        ST_DONE: begin
          if (take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/nurbs_point_tangent_eval.sv
// Planar NURBS evaluator. Knot and control-point load requests are taken while the evaluator
// is idle and write the knot memory or the control memory (x, y, weight); neither memory is
// cleared after reset. An evaluate request returns the curve point and first derivative in
// Q15.16 after span bisection; every basis and derivative term and the four final quotients
// pass through one shared divider that produces one quotient bit per cycle, and the products
// and weighted sums go through a 64x64 multiplier built from four 32x32 partial products. The
// block takes one evaluation at a time; a finished result sits in the output register while
// the next request is accepted.
module nurbs_point_tangent_eval import npt_pkg::*; #(
  parameter int FRAC_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_en,
  input  logic       reg_index,
  input  logic [6:0] write_data,
  npt_req_if.sink    request,
  npt_rsp_if.source  result
);

  localparam int KNOT_DEPTH = CONTROL_CAP + DEGREE_CAP + 1;
  localparam int KW         = $clog2(KNOT_DEPTH);
  localparam int CW         = $clog2(CONTROL_CAP);

  cfg_t               cfg;
  logic               accept;
  logic               knot_we;
  logic               ctrl_we;
  logic               eval_start;
  logic               eval_idle;
  logic               eval_done;
  logic               take;
  logic [KW-1:0]      knot_addr;
  logic [CW-1:0]      ctrl_addr;
  logic signed [31:0] knot_q;
  ctrl_entry_t        ctrl_q;
  result_t            eval_res;
  logic signed [31:0] knot_mem [KNOT_DEPTH];
  ctrl_entry_t        ctrl_mem [CONTROL_CAP];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.degree <= 2'd1;
      cfg.count  <= 7'd2;
    end else if (write_en) begin
      unique case (reg_index)
        REG_DEGREE: cfg.degree <= write_data[1:0];
        REG_COUNT:  cfg.count  <= write_data;
        default:    cfg.count  <= cfg.count;
      endcase
    end
  end

  // Decode an accepted request
  assign request.ready = eval_idle;
  assign accept        = request.valid & request.ready;

  always_comb begin
    knot_we    = 1'b0;
    ctrl_we    = 1'b0;
    eval_start = 1'b0;
    if (accept) begin
      unique case (request.kind)
        KIND_KNOT: knot_we    = int'(request.slot_index) < KNOT_DEPTH;
        KIND_CTRL: ctrl_we    = int'(request.slot_index) < CONTROL_CAP;
        KIND_EVAL: eval_start = 1'b1;
        default:   eval_start = 1'b0;
      endcase
    end
  end

  // Knot and control memories, registered read
  always_ff @(posedge clk) begin
    if (knot_we) knot_mem[KW'(request.slot_index)] <= request.first_value;
    knot_q <= knot_mem[knot_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl_we) begin
      ctrl_mem[CW'(request.slot_index)] <= '{x: request.first_value,
                                             y: request.second_value,
                                             w: request.weight_value};
    end
    ctrl_q <= ctrl_mem[ctrl_addr];
  end

  npt_eval #(
    .FRAC_BITS   (FRAC_BITS)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .start    (eval_start),
    .u        (request.first_value),
    .cfg      (cfg),
    .knot_addr(knot_addr),
    .knot_q   (knot_q),
    .ctrl_addr(ctrl_addr),
    .ctrl_q   (ctrl_q),
    .idle     (eval_idle),
    .done     (eval_done),
    .take     (take),
    .res      (eval_res)
  );

  // Output register: load when empty or being drained
  assign take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (eval_done && take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_done && take) begin
      result.point_x   <= eval_res.point_x;
      result.point_y   <= eval_res.point_y;
      result.tangent_x <= eval_res.tangent_x;
      result.tangent_y <= eval_res.tangent_y;
      result.status    <= eval_res.status;
    end
  end

endmodule

>>> src/npt_checker.sv
// Port-level checks for the NURBS evaluator, bound to the top level.
module npt_checker import npt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [1:0]         req_kind,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] rsp_point_x,
  input logic signed [31:0] rsp_point_y,
  input logic signed [31:0] rsp_tangent_x,
  input logic signed [31:0] rsp_tangent_y,
  input logic [1:0]         rsp_status
);

  // No result directly after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // An evaluate request closes the request side for the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_kind == KIND_EVAL |=> !req_ready)
    else $error("request taken while an evaluation runs");

  // Zero denominator gives zero values
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STATUS_ZERO_DEN |->
      rsp_point_x == '0 && rsp_point_y == '0 && rsp_tangent_x == '0 && rsp_tangent_y == '0)
    else $error("nonzero values with zero denominator");

  // Status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_ZERO_DEN ||
                  rsp_status == STATUS_SAT)
    else $error("bad status code");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_status))
    else $error("result changed while stalled");

endmodule

bind nurbs_point_tangent_eval npt_checker u_npt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (request.valid),
  .req_ready    (request.ready),
  .req_kind     (request.kind),
  .rsp_valid    (result.valid),
  .rsp_ready    (result.ready),
  .rsp_point_x  (result.point_x),
  .rsp_point_y  (result.point_y),
  .rsp_tangent_x(result.tangent_x),
  .rsp_tangent_y(result.tangent_y),
  .rsp_status   (result.status)
);

>>> test/tb_nurbs_point_tangent_eval.sv
// Testbench for the NURBS point and tangent evaluator: directed and random requests checked
// against a cycle-free predictor.
module tb_nurbs_point_tangent_eval;
  import npt_pkg::*;

  localparam int          KNOT_SLOTS  = 68;
  localparam int          CTRL_SLOTS  = 64;
  localparam int          DEG_MAX     = 3;
  localparam int          FRAC        = 16;
  localparam logic [1:0]  KIND_IGNORE = 2'd3;
  localparam longint      CYCLE_LIMIT = 8000000;
  localparam logic [31:0] ONE         = 32'h0001_0000;

  logic       clk = 1'b0;
  logic       rst;
  logic       write_en;
  logic       reg_index;
  logic [6:0] write_data;

  npt_req_if req_ch();
  npt_rsp_if rsp_ch();

  nurbs_point_tangent_eval u_dut (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .request    (req_ch),
    .result     (rsp_ch)
  );

  // Predictor state
  longint     knot_mem [KNOT_SLOTS];
  longint     cx_mem   [CTRL_SLOTS];
  longint     cy_mem   [CTRL_SLOTS];
  longint     wt_mem   [CTRL_SLOTS];
  logic [1:0] cfg_degree;
  logic [6:0] cfg_count;
  bit         sat_hit;

  result_t    pending_results[$];
  int         fail_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  longint     cycle_count;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] abs64(input longint a);
    logic [63:0] ua;
    ua = a;
    return a[63] ? (~ua + 64'd1) : ua;
  endfunction

  function automatic longint signed_clip(input logic [127:0] m, input bit neg);
    logic [127:0] mm;
    mm = m;
    if (mm > {64'd0, MAXV}) begin
      sat_hit = 1'b1;
      mm      = {64'd0, MAXV};
    end
    return neg ? -longint'(mm[63:0]) : longint'(mm[63:0]);
  endfunction

  function automatic longint mul_sh(input longint a, input longint b, input int sh);
    logic [127:0] prod;
    prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    prod = prod >> sh;
    return signed_clip(prod, (a < 0) != (b < 0));
  endfunction

  function automatic longint div_sh(input longint a, input longint b, input int sh);
    logic [63:0]  dv;
    logic [127:0] num;
    bit           neg;
    dv  = abs64(b);
    neg = (a < 0) != (b < 0);
    if (dv == 64'd0) return 0;
    num = {64'd0, abs64(a)} << sh;
    if (num[127:64] >= dv) begin
      sat_hit = 1'b1;
      return neg ? -MAXV : MAXV;
    end
    return signed_clip(num / {64'd0, dv}, neg);
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    lim = $signed({1'b0, MAXV});
    s   = $signed({a[63], a}) + $signed({b[63], b});
    if (s > lim) begin
      sat_hit = 1'b1;
      return MAXV;
    end
    if (s < -lim) begin
      sat_hit = 1'b1;
      return -MAXV;
    end
    return longint'(s[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      sat_hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------- curve model
  function automatic int eff_degree();
    int p;
    p = cfg_degree;
    if (p < 1) p = 1;
    if (p > DEG_MAX) p = DEG_MAX;
    return p;
  endfunction

  function automatic int eff_count(input int p);
    int m;
    m = cfg_count;
    if (m < p + 1) m = p + 1;
    if (m > CTRL_SLOTS) m = CTRL_SLOTS;
    return m;
  endfunction

  function automatic int find_span(input int p, input int n, input longint u);
    int lo;
    int hi;
    int mid;
    lo = p;
    hi = n + 1;
    if (u >= knot_mem[n + 1]) return n;
    if (u <= knot_mem[p]) return p;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (u < knot_mem[mid]) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic result_t eval_curve(input longint u);
    longint  bas [DEG_MAX+1][DEG_MAX+1];
    longint  dn  [DEG_MAX+1];
    longint  ax, ay, ws, dax, day, dws, px, py, den, s, wi, wx, wy;
    int      p, n, span, idx;
    result_t r;
    p       = eff_degree();
    n       = eff_count(p) - 1;
    sat_hit = 1'b0;
    span    = find_span(p, n, u);
    for (int d = 0; d <= DEG_MAX; d++)
      for (int j = 0; j <= DEG_MAX; j++) bas[d][j] = 0;
    bas[0][0] = longint'(1) << BASIS_FRAC;
    // Cox-de Boor recursion, skipping zero-length knot intervals
    for (int d = 1; d <= p; d++) begin
      for (int j = 0; j <= d; j++) begin
        s   = 0;
        idx = span - d + j;
        if (j > 0) begin
          den = knot_mem[idx + d] - knot_mem[idx];
          if (den != 0)
            s = add_sat(s, mul_sh(div_sh(u - knot_mem[idx], den, BASIS_FRAC),
                                  bas[d-1][j-1], BASIS_FRAC));
        end
        if (j < d) begin
          den = knot_mem[idx + d + 1] - knot_mem[idx + 1];
          if (den != 0)
            s = add_sat(s, mul_sh(div_sh(knot_mem[idx + d + 1] - u, den, BASIS_FRAC),
                                  bas[d-1][j], BASIS_FRAC));
        end
        bas[d][j] = s;
      end
    end
    // First derivatives of the basis
    for (int j = 0; j <= p; j++) begin
      s   = 0;
      idx = span - p + j;
      if (j > 0) begin
        den = knot_mem[idx + p] - knot_mem[idx];
        if (den != 0) s = add_sat(s, div_sh(bas[p-1][j-1], den, FRAC));
      end
      if (j < p) begin
        den = knot_mem[idx + p + 1] - knot_mem[idx + 1];
        if (den != 0) s = add_sat(s, -div_sh(bas[p-1][j], den, FRAC));
      end
      dn[j] = mul_sh(s, longint'(p), 0);
    end
    // Weighted sums
    ax = 0; ay = 0; ws = 0; dax = 0; day = 0; dws = 0;
    for (int j = 0; j <= p; j++) begin
      idx = span - p + j;
      wi  = wt_mem[idx];
      wx  = wi * cx_mem[idx];
      wy  = wi * cy_mem[idx];
      ax  = add_sat(ax, mul_sh(bas[p][j], wx, BASIS_FRAC));
      ay  = add_sat(ay, mul_sh(bas[p][j], wy, BASIS_FRAC));
      ws  = add_sat(ws, mul_sh(bas[p][j], wi, BASIS_FRAC));
      dax = add_sat(dax, mul_sh(dn[j], wx, BASIS_FRAC));
      day = add_sat(day, mul_sh(dn[j], wy, BASIS_FRAC));
      dws = add_sat(dws, mul_sh(dn[j], wi, BASIS_FRAC));
    end
    if (ws == 0) begin
      r.point_x   = '0;
      r.point_y   = '0;
      r.tangent_x = '0;
      r.tangent_y = '0;
      r.status    = STATUS_ZERO_DEN;
      return r;
    end
    px          = div_sh(ax, ws, 0);
    py          = div_sh(ay, ws, 0);
    r.tangent_x = clip32(div_sh(add_sat(dax, -mul_sh(px, dws, 0)), ws, 0));
    r.tangent_y = clip32(div_sh(add_sat(day, -mul_sh(py, dws, 0)), ws, 0));
    r.point_x   = clip32(px);
    r.point_y   = clip32(py);
    r.status    = sat_hit ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Send one request, then update the predictor once it is taken
  task automatic send_item(input logic [1:0] kind, input logic [6:0] slot,
                           input logic [31:0] v1, input logic [31:0] v2,
                           input logic [30:0] wt);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.slot_index   <= slot;
    req_ch.first_value  <= v1;
    req_ch.second_value <= v2;
    req_ch.weight_value <= wt;
    do @(posedge clk); while (!req_ch.ready);
    case (kind)
      KIND_KNOT: if (slot < KNOT_SLOTS) knot_mem[slot] = longint'($signed(v1));
      KIND_CTRL: begin
        if (slot < CTRL_SLOTS) begin
          cx_mem[slot] = longint'($signed(v1));
          cy_mem[slot] = longint'($signed(v2));
          wt_mem[slot] = longint'({33'd0, wt});
        end
      end
      KIND_EVAL: pending_results.push_back(eval_curve(longint'($signed(v1))));
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [6:0] data);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= data;
    @(negedge clk);
    if (idx == REG_DEGREE) cfg_degree = data[1:0];
    else cfg_count = data;
  endtask

  task automatic set_curve(input logic [6:0] deg_data, input logic [6:0] count_data);
    wait_idle();
    write_reg(REG_DEGREE, deg_data);
    write_reg(REG_COUNT, count_data);
    write_en <= 1'b0;
  endtask

  task automatic eval_at(input logic [31:0] u);
    send_item(KIND_EVAL, 7'd0, u, $urandom, 31'($urandom));
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: x=%h y=%h tx=%h ty=%h st=%0d", rsp_ch.point_x,
                   rsp_ch.point_y, rsp_ch.tangent_x, rsp_ch.tangent_y, rsp_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.point_x !== want.point_x || rsp_ch.point_y !== want.point_y ||
            rsp_ch.tangent_x !== want.tangent_x || rsp_ch.tangent_y !== want.tangent_y ||
            rsp_ch.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp x=%h y=%h tx=%h ty=%h st=%0d got x=%h y=%h tx=%h ty=%h st=%0d",
                     want.point_x, want.point_y, want.tangent_x, want.tangent_y, want.status,
                     rsp_ch.point_x, rsp_ch.point_y, rsp_ch.tangent_x, rsp_ch.tangent_y,
                     rsp_ch.status);
        end
      end
    end
  end

  // Randomize result backpressure
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_nurbs_point_tangent_eval failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // Write every store entry so no evaluation reads an unwritten one
  task automatic preload_stores();
    for (int i = 0; i < KNOT_SLOTS; i++)
      send_item(KIND_KNOT, i[6:0], i * ONE, $urandom, 31'($urandom));
    for (int i = 0; i < CTRL_SLOTS; i++)
      send_item(KIND_CTRL, i[6:0], $urandom_range(0, 1 << 22) - (1 << 21),
                $urandom_range(0, 1 << 22) - (1 << 21),
                31'($urandom_range(1 << 15, 1 << 17)));
  endtask

  task automatic test_defaults();
    eval_at(32'h0001_8000);
    eval_at(ONE);
  endtask

  task automatic test_config_extremes();
    set_curve(7'd3, 7'd64);
    eval_at(30 * ONE);
    eval_at(32'h7FFF_FFFF);
    eval_at(32'h8000_0000);
    // degree zero runs as one, count below the minimum is raised
    set_curve(7'b1111100, 7'd0);
    eval_at(32'h0000_C000);
    set_curve(7'd2, 7'd127);
    eval_at(50 * ONE + 32'h1234);
  endtask

  task automatic test_special_cases();
    send_item(KIND_IGNORE, 7'd3, $urandom, $urandom, 31'($urandom));
    send_item(KIND_KNOT, 7'd68, 32'h7FFF_FFFF, 32'd0, 31'd0);
    send_item(KIND_KNOT, 7'd127, 32'h8000_0000, 32'd0, 31'd0);
    send_item(KIND_CTRL, 7'd64, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(KIND_CTRL, 7'd127, 32'd0, 32'd0, 31'd1);
    send_item(KIND_CTRL, 7'd5, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(KIND_CTRL, 7'd6, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
    set_curve(7'd2, 7'd8);
    eval_at(6 * ONE);
    eval_at(32'h7FFF_FFFF);
    // unsorted knots still end the span search
    send_item(KIND_KNOT, 7'd4, 32'h8000_0000, 32'd0, 31'd0);
    eval_at(5 * ONE);
    // coincident knots leave every basis term out: zero denominator
    set_curve(7'd1, 7'd2);
    for (int i = 0; i < 4; i++) send_item(KIND_KNOT, i[6:0], ONE, 32'd0, 31'd0);
    eval_at(ONE);
  endtask

  function automatic logic [31:0] rand_coord();
    return ($urandom_range(9) < 7) ? $urandom_range(0, 1 << 24) - (1 << 23) : $urandom;
  endfunction

  function automatic logic [30:0] rand_weight();
    return ($urandom_range(9) < 8) ? 31'($urandom_range(1 << 14, 1 << 18))
                                   : 31'($urandom_range(1, 32'h7FFF_FFFF));
  endfunction

  // Whole curves with random content, mixed with noise requests
  task automatic test_random(input int s_pct, input int r_pct, input int n_items);
    int          sent;
    int          p, m, step_max, evals;
    logic [31:0] kv, lo_u, hi_u, u;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        p = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
        case ($urandom_range(19))
          0:       m = 64;
          1:       m = $urandom_range(0, 127);
          default: m = $urandom_range(2, 8);
        endcase
        set_curve({5'($urandom_range(0, 31)), p[1:0]}, m[6:0]);
        p = eff_degree();
        m = eff_count(p);
        case ($urandom_range(2))
          0:       step_max = 1 << 10;
          1:       step_max = 1 << 16;
          default: step_max = 1 << 22;
        endcase
        kv = $urandom_range(0, 1 << 20) - (1 << 19);
        for (int i = 0; i <= m + p; i++) begin
          if (i > 0 && $urandom_range(9) >= 3) kv = kv + $urandom_range(1, step_max);
          send_item(KIND_KNOT, i[6:0], kv, $urandom, 31'($urandom));
          sent++;
        end
        for (int i = 0; i < m; i++) begin
          send_item(KIND_CTRL, i[6:0], rand_coord(), rand_coord(), rand_weight());
          sent++;
        end
        lo_u  = knot_mem[p][31:0];
        hi_u  = knot_mem[m][31:0];
        evals = $urandom_range(3, 8);
        for (int e = 0; e < evals; e++) begin
          case ($urandom_range(19))
            0, 1:    u = knot_mem[$urandom_range(0, m + p)][31:0];
            2, 3:    u = $urandom;
            default: u = lo_u + $urandom_range(0, hi_u - lo_u);
          endcase
          eval_at(u);
          sent++;
          if ($urandom_range(49) == 0) wait_idle();
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom,
                    $urandom, 31'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    write_en            = 1'b0;
    reg_index           = REG_DEGREE;
    write_data          = '0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_KNOT;
    req_ch.slot_index   = '0;
    req_ch.first_value  = '0;
    req_ch.second_value = '0;
    req_ch.weight_value = '0;
    rsp_ch.ready        = 1'b0;
    cfg_degree          = 2'd1;
    cfg_count           = 7'd2;
    fail_count          = 0;
    cycle_count         = 0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    for (int i = 0; i < KNOT_SLOTS; i++) knot_mem[i] = 0;
    for (int i = 0; i < CTRL_SLOTS; i++) begin
      cx_mem[i] = 0;
      cy_mem[i] = 0;
      wt_mem[i] = 0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    preload_stores();
    test_defaults();
    test_config_extremes();
    test_special_cases();
    test_random(29, 81, 200);
    test_random(81, 29, 200);
    test_random(0, 0, 200);

    wait_idle();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_nurbs_point_tangent_eval passed");
    end else begin
      $display("tb_nurbs_point_tangent_eval failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/npt_pkg.sv
src/npt_if.sv
src/npt_mul.sv
src/npt_div.sv
src/npt_eval.sv
src/nurbs_point_tangent_eval.sv
src/npt_checker.sv
test/tb_nurbs_point_tangent_eval.sv
